// ===== rtl/core/rrsp_pkg.sv =====
// shared types and constants for the resp reply stream parser
// depends on nothing; used by every module under rtl/core
`default_nettype none

package rrsp_pkg;

    // received bytes with a meaning to the parser
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    // result kinds
    localparam logic [1:0] K_BYTE  = 2'd0;
    localparam logic [1:0] K_END   = 2'd1;
    localparam logic [1:0] K_NIL   = 2'd2;
    localparam logic [1:0] K_FAULT = 2'd3;

    // element classes
    localparam logic [2:0] CL_SIMPLE = 3'd0;
    localparam logic [2:0] CL_ERROR  = 3'd1;
    localparam logic [2:0] CL_INT    = 3'd2;
    localparam logic [2:0] CL_BULK   = 3'd3;
    localparam logic [2:0] CL_ARRAY  = 3'd4;

    // fault codes
    localparam logic [2:0] F_NONE    = 3'd0;
    localparam logic [2:0] F_CLOSED  = 3'd1;
    localparam logic [2:0] F_UNKNOWN = 3'd2;
    localparam logic [2:0] F_BADLEN  = 3'd3;
    localparam logic [2:0] F_TOOLONG = 3'd4;
    localparam logic [2:0] F_TOODEEP = 3'd5;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       conn_closed;
    } in_word_t;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [2:0] text_class;
        logic [7:0] out_byte;
        logic [2:0] fault_code;
        logic [3:0] levels_closed;
        logic       more_follows;
        logic       reply_done;
    } out_word_t;

    // byte classes found by the front
    typedef enum logic [2:0] {
        CH_OTHER,
        CH_CR,
        CH_MINUS,
        CH_DIGIT,
        CH_PLUS,
        CH_COLON,
        CH_DOLLAR,
        CH_STAR
    } chr_t;

    typedef struct packed {
        logic       closed;
        chr_t       chr;
        logic [3:0] digit;
        logic [7:0] rx_byte;
    } qword_t;

endpackage

`default_nettype wire

// ===== rtl/core/rrsp_front.sv =====
// front end: accepts input words and classifies each received byte
// depends on rrsp_pkg
`default_nettype none

module rrsp_front (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  rrsp_pkg::in_word_t  s_data,
    input  wire                 queue_full,
    output logic                push_valid,
    output rrsp_pkg::qword_t    push_word
);

    rrsp_pkg::chr_t chr;
    logic [7:0]     diff;

    always_comb begin
        diff = s_data.rx_byte - rrsp_pkg::CHAR_ZERO;
        case (s_data.rx_byte) inside
            rrsp_pkg::CHAR_CR:                          chr = rrsp_pkg::CH_CR;
            rrsp_pkg::CHAR_MINUS:                       chr = rrsp_pkg::CH_MINUS;
            rrsp_pkg::CHAR_PLUS:                        chr = rrsp_pkg::CH_PLUS;
            rrsp_pkg::CHAR_COLON:                       chr = rrsp_pkg::CH_COLON;
            rrsp_pkg::CHAR_DOLLAR:                      chr = rrsp_pkg::CH_DOLLAR;
            rrsp_pkg::CHAR_STAR:                        chr = rrsp_pkg::CH_STAR;
            [rrsp_pkg::CHAR_ZERO:rrsp_pkg::CHAR_NINE]:  chr = rrsp_pkg::CH_DIGIT;
            default:                                    chr = rrsp_pkg::CH_OTHER;
        endcase
    end

    assign s_ready              = aresetn && !queue_full;
    assign push_valid           = s_valid && s_ready;
    assign push_word.closed     = s_data.conn_closed;
    assign push_word.chr        = chr;
    assign push_word.digit      = diff[3:0];
    assign push_word.rx_byte    = s_data.rx_byte;

    // aclk unused in logic beyond documenting the clock domain
    logic unused_clk;
    assign unused_clk = aclk;

endmodule

`default_nettype wire

// ===== rtl/core/rrsp_queue.sv =====
// short word queue between the classifying front and the parsing back
// depends on rrsp_pkg
`default_nettype none

module rrsp_queue (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               push_valid,
    input  rrsp_pkg::qword_t  push_word,
    output logic              full,
    output logic              pop_valid,
    input  wire               pop_ready,
    output rrsp_pkg::qword_t  pop_word
);

    rrsp_pkg::qword_t                 slots_reg [rrsp_pkg::QUEUE_DEPTH];
    logic [rrsp_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [rrsp_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [rrsp_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                             do_push, do_pop;

    assign full      = (count_reg == rrsp_pkg::QCNT_W'(rrsp_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_word  = slots_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rrsp_back.sv =====
// back end: reply state machine, open-array stack and result register
// depends on rrsp_pkg
`default_nettype none

module rrsp_back #(
    parameter int MAX_DEPTH  = 8,
    parameter int MAX_LENGTH = 65535
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  q_valid,
    output logic                 q_ready,
    input  rrsp_pkg::qword_t     q_word,
    output logic                 m_valid,
    input  wire                  m_ready,
    output rrsp_pkg::out_word_t  m_data
);

    localparam int LEN_W = $clog2(MAX_LENGTH + 2);
    localparam int LVL_W = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam logic [LEN_W-1:0] MAXL   = LEN_W'(MAX_LENGTH);
    localparam logic [LEN_W-1:0] SATL   = LEN_W'(MAX_LENGTH + 1);
    localparam logic [LEN_W+3:0] MAXL_X = (LEN_W + 4)'(MAX_LENGTH);
    localparam logic [LVL_W-1:0] DEPTH_L = LVL_W'(MAX_DEPTH);

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_LINE,
        PH_LINE_LF,
        PH_LEN,
        PH_LEN_LF,
        PH_BULK,
        PH_TRAIL_A,
        PH_TRAIL_B
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [2:0]           class_reg, class_next;
    logic [LEN_W-1:0]     accum_reg, accum_next;
    logic                 neg_reg, neg_next;
    logic                 seen_reg, seen_next;
    logic [LEN_W-1:0]     bulk_reg, bulk_next;
    logic [LVL_W-1:0]     nest_reg, nest_next;
    logic                 m_valid_reg, m_valid_next;
    rrsp_pkg::out_word_t  m_data_reg, m_data_next;

    // open-array stack: remaining count and a "more than one left" flag
    logic [LEN_W-1:0]     counts_reg [MAX_DEPTH];
    logic [MAX_DEPTH-1:0] gt1_reg;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    logic [LEN_W-1:0]     wr_count;
    logic                 wr_gt1;

    logic                 out_free, pop;
    logic                 res_valid;
    rrsp_pkg::out_word_t  res;
    logic                 do_finish, do_abort;
    logic [1:0]           fin_kind;
    logic [2:0]           fin_class, fin_fault;
    logic [2:0]           ab_class, ab_fault;

    // finish search over open levels
    logic                 found;
    logic [IDX_W-1:0]     found_idx;
    logic [LVL_W-1:0]     fin_levels;
    logic [LVL_W-1:0]     fin_nest;
    logic [LEN_W-1:0]     found_count;
    logic [LEN_W+3:0]     prod;

    assign out_free = !m_valid_reg || m_ready;
    assign q_ready  = out_free;
    assign pop      = q_valid && out_free;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = 0; i < MAX_DEPTH; i++) begin
            if (gt1_reg[i] && (LVL_W'(i) < nest_reg)) begin
                found     = 1'b1;
                found_idx = IDX_W'(i);
            end
        end
        found_count = counts_reg[found_idx];
        if (found) begin
            fin_nest   = LVL_W'(found_idx) + 1'b1;
            fin_levels = nest_reg - fin_nest;
        end else begin
            fin_nest   = '0;
            fin_levels = nest_reg;
        end
    end

    assign prod = {accum_reg, 3'b000} + {2'b00, accum_reg, 1'b0} + (LEN_W + 4)'(q_word.digit);

    always_comb begin
        phase_next   = phase_reg;
        class_next   = class_reg;
        accum_next   = accum_reg;
        neg_next     = neg_reg;
        seen_next    = seen_reg;
        bulk_next    = bulk_reg;
        nest_next    = nest_reg;
        wr_en        = 1'b0;
        wr_idx       = nest_reg[IDX_W-1:0];
        wr_count     = accum_reg;
        wr_gt1       = 1'b0;
        res_valid    = 1'b0;
        res          = '0;
        do_finish    = 1'b0;
        do_abort     = 1'b0;
        fin_kind     = rrsp_pkg::K_END;
        fin_class    = class_reg;
        fin_fault    = rrsp_pkg::F_NONE;
        ab_class     = class_reg;
        ab_fault     = rrsp_pkg::F_NONE;

        if (pop) begin
            if (q_word.closed) begin
                class_next = rrsp_pkg::CL_SIMPLE;
                do_abort   = 1'b1;
                ab_class   = rrsp_pkg::CL_SIMPLE;
                ab_fault   = rrsp_pkg::F_CLOSED;
            end else begin
                case (phase_reg)
                    PH_PREFIX: begin
                        case (q_word.chr)
                            rrsp_pkg::CH_PLUS: begin
                                class_next = rrsp_pkg::CL_SIMPLE;
                                phase_next = PH_LINE;
                            end
                            rrsp_pkg::CH_MINUS: begin
                                class_next = rrsp_pkg::CL_ERROR;
                                phase_next = PH_LINE;
                            end
                            rrsp_pkg::CH_COLON: begin
                                class_next = rrsp_pkg::CL_INT;
                                phase_next = PH_LINE;
                            end
                            rrsp_pkg::CH_DOLLAR: begin
                                class_next = rrsp_pkg::CL_BULK;
                                phase_next = PH_LEN;
                                accum_next = '0;
                                neg_next   = 1'b0;
                                seen_next  = 1'b0;
                            end
                            rrsp_pkg::CH_STAR: begin
                                class_next = rrsp_pkg::CL_ARRAY;
                                phase_next = PH_LEN;
                                accum_next = '0;
                                neg_next   = 1'b0;
                                seen_next  = 1'b0;
                            end
                            default: begin
                                // unknown prefix counts as one finished element
                                class_next = rrsp_pkg::CL_SIMPLE;
                                do_finish  = 1'b1;
                                fin_kind   = rrsp_pkg::K_FAULT;
                                fin_class  = rrsp_pkg::CL_SIMPLE;
                                fin_fault  = rrsp_pkg::F_UNKNOWN;
                            end
                        endcase
                    end
                    PH_LINE: begin
                        if (q_word.chr == rrsp_pkg::CH_CR) begin
                            phase_next = PH_LINE_LF;
                        end else begin
                            res_valid      = 1'b1;
                            res.out_kind   = rrsp_pkg::K_BYTE;
                            res.text_class = class_reg;
                            res.out_byte   = q_word.rx_byte;
                        end
                    end
                    PH_LEN: begin
                        if (q_word.chr == rrsp_pkg::CH_CR) begin
                            phase_next = PH_LEN_LF;
                        end else if (q_word.chr == rrsp_pkg::CH_MINUS && !seen_reg
                                     && !neg_reg) begin
                            neg_next = 1'b1;
                        end else if (q_word.chr != rrsp_pkg::CH_DIGIT) begin
                            do_abort = 1'b1;
                            ab_fault = rrsp_pkg::F_BADLEN;
                        end else begin
                            seen_next = 1'b1;
                            if (accum_reg <= MAXL) begin
                                accum_next = (prod > MAXL_X) ? SATL : prod[LEN_W-1:0];
                            end
                        end
                    end
                    PH_LEN_LF: begin
                        if (!seen_reg) begin
                            do_abort = 1'b1;
                            ab_fault = rrsp_pkg::F_BADLEN;
                        end else if (neg_reg && accum_reg == LEN_W'(1)) begin
                            do_finish = 1'b1;
                            fin_kind  = rrsp_pkg::K_NIL;
                        end else if (neg_reg && accum_reg != '0) begin
                            do_abort = 1'b1;
                            ab_fault = rrsp_pkg::F_BADLEN;
                        end else if (accum_reg > MAXL) begin
                            do_abort = 1'b1;
                            ab_fault = rrsp_pkg::F_TOOLONG;
                        end else begin
                            accum_next = '0;
                            neg_next   = 1'b0;
                            seen_next  = 1'b0;
                            if (class_reg == rrsp_pkg::CL_BULK) begin
                                bulk_next  = accum_reg;
                                phase_next = (accum_reg != '0) ? PH_BULK : PH_TRAIL_A;
                            end else if (accum_reg == '0) begin
                                // empty array is a finished element
                                do_finish = 1'b1;
                                fin_class = rrsp_pkg::CL_ARRAY;
                            end else if (nest_reg >= DEPTH_L) begin
                                do_abort = 1'b1;
                                ab_fault = rrsp_pkg::F_TOODEEP;
                            end else begin
                                wr_en      = 1'b1;
                                wr_idx     = nest_reg[IDX_W-1:0];
                                wr_count   = accum_reg;
                                wr_gt1     = (accum_reg > LEN_W'(1));
                                nest_next  = nest_reg + 1'b1;
                                phase_next = PH_PREFIX;
                            end
                        end
                    end
                    PH_BULK: begin
                        if (bulk_reg == LEN_W'(1) || bulk_reg == '0) begin
                            phase_next = PH_TRAIL_A;
                        end
                        if (bulk_reg != '0) begin
                            bulk_next = bulk_reg - 1'b1;
                        end
                        res_valid      = 1'b1;
                        res.out_kind   = rrsp_pkg::K_BYTE;
                        res.text_class = class_reg;
                        res.out_byte   = q_word.rx_byte;
                    end
                    PH_TRAIL_A: begin
                        phase_next = PH_TRAIL_B;
                    end
                    default: begin
                        // byte after cr of a line, or second trailer byte
                        do_finish = 1'b1;
                    end
                endcase
            end

            if (do_finish) begin
                phase_next = PH_PREFIX;
                accum_next = '0;
                neg_next   = 1'b0;
                seen_next  = 1'b0;
                nest_next  = fin_nest;
                if (found) begin
                    wr_en    = 1'b1;
                    wr_idx   = found_idx;
                    wr_count = found_count - 1'b1;
                    wr_gt1   = (found_count > LEN_W'(2));
                end
                res_valid         = 1'b1;
                res.out_kind      = fin_kind;
                res.text_class    = fin_class;
                res.fault_code    = fin_fault;
                res.levels_closed = 4'(fin_levels);
                res.more_follows  = found;
                res.reply_done    = !found;
            end

            if (do_abort) begin
                phase_next     = PH_PREFIX;
                accum_next     = '0;
                neg_next       = 1'b0;
                seen_next      = 1'b0;
                bulk_next      = '0;
                nest_next      = '0;
                res_valid      = 1'b1;
                res.out_kind   = rrsp_pkg::K_FAULT;
                res.text_class = ab_class;
                res.fault_code = ab_fault;
                res.reply_done = 1'b1;
            end
        end

        if (pop && res_valid) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
            m_data_next  = m_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_PREFIX;
            class_reg   <= rrsp_pkg::CL_SIMPLE;
            accum_reg   <= '0;
            neg_reg     <= 1'b0;
            seen_reg    <= 1'b0;
            bulk_reg    <= '0;
            nest_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            class_reg   <= class_next;
            accum_reg   <= accum_next;
            neg_reg     <= neg_next;
            seen_reg    <= seen_next;
            bulk_reg    <= bulk_next;
            nest_reg    <= nest_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
        if (wr_en) begin
            counts_reg[wr_idx] <= wr_count;
            gt1_reg[wr_idx]    <= wr_gt1;
        end
    end

    a_nest_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        nest_reg <= DEPTH_L)
        else $error("open array level beyond max depth");

    a_abort_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.out_kind == rrsp_pkg::K_FAULT
         && m_data_reg.fault_code != rrsp_pkg::F_UNKNOWN)
        |-> (m_data_reg.reply_done && !m_data_reg.more_follows
             && m_data_reg.levels_closed == 4'd0))
        else $error("aborting fault did not close the reply");

    a_byte_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.out_kind == rrsp_pkg::K_BYTE)
        |-> (m_data_reg.fault_code == rrsp_pkg::F_NONE && !m_data_reg.reply_done
             && !m_data_reg.more_follows && m_data_reg.levels_closed == 4'd0))
        else $error("content word carries element flags");

    a_closed_reports: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && q_word.closed)
        |=> (m_valid_reg && m_data_reg.fault_code == rrsp_pkg::F_CLOSED
             && nest_reg == '0 && phase_reg == PH_PREFIX))
        else $error("connection close not reported");

endmodule

`default_nettype wire

// ===== rtl/core/resp_reply_stream_parser.sv =====
// resp reply stream parser: one reply byte in, content bytes and element markers out
// path: an accepted byte is written into the queue, then parsed from it into the result register
// throughput: one byte per cycle unless a result word held by m_ready stalls the back
// reset: synchronous active-low aresetn; array stack contents stay undefined
// depends on rrsp_pkg, rrsp_front, rrsp_queue, rrsp_back
`default_nettype none

module resp_reply_stream_parser #(
    parameter int MAX_DEPTH  = 8,
    parameter int MAX_LENGTH = 65535
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    // input word channel
    input  wire                  s_valid,
    output logic                 s_ready,
    input  rrsp_pkg::in_word_t   s_data,
    // result word channel
    output logic                 m_valid,
    input  wire                  m_ready,
    output rrsp_pkg::out_word_t  m_data
);

    // front to queue
    logic              push_valid;
    rrsp_pkg::qword_t  push_word;
    logic              queue_full;

    // queue to back
    logic              q_valid;
    logic              q_ready;
    rrsp_pkg::qword_t  q_word;

    // front classifies each byte (cr, minus, digit, prefixes) as it is accepted
    rrsp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_word  (push_word)
    );

    // short queue so input acceptance stalls on result backpressure only once it is full
    rrsp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_word  (push_word),
        .full       (queue_full),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_word   (q_word)
    );

    // back runs the reply state machine and the open-array stack;
    // it pops a word only when its result register is free or draining
    rrsp_back #(
        .MAX_DEPTH  (MAX_DEPTH),
        .MAX_LENGTH (MAX_LENGTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_word  (q_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// testbench for resp_reply_stream_parser: directed and random reply byte streams,
// results checked word by word against an in-line parse predictor
// depends on rrsp_pkg and the resp_reply_stream_parser rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rrsp_pkg::*;

    localparam int MAX_DEPTH    = 8;
    localparam int MAX_LENGTH   = 65535;
    localparam int LIMIT_CYCLES = 300000;
    localparam int DRAIN_CYCLES = 20;

    // parser phases as the predictor tracks them
    typedef enum logic [2:0] {
        P_PREFIX,
        P_LINE,
        P_LINE_LF,
        P_LEN,
        P_LEN_LF,
        P_BULK,
        P_TRAIL_A,
        P_TRAIL_B
    } parse_phase_e;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    resp_reply_stream_parser #(
        .MAX_DEPTH (MAX_DEPTH),
        .MAX_LENGTH(MAX_LENGTH)
    ) u_top (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // predictor state, mirrors the parser after reset
    parse_phase_e pp_phase     = P_PREFIX;
    logic [2:0]   pp_class     = CL_SIMPLE;
    int           pp_len       = 0;
    logic         pp_neg       = 1'b0;
    logic         pp_digit     = 1'b0;
    int           pp_bulk_left = 0;
    int           pp_counts[MAX_DEPTH];
    int           pp_nest      = 0;

    out_word_t parsed_words[$];    // result words still to arrive, oldest first
    logic [7:0] reply_q[$];        // bytes of the reply being built
    int  words_in      = 0;        // input words accepted so far
    int  n_fail        = 0;
    int  cycle_cnt     = 0;
    int  hold_cycles   = 0;        // long receiver hold-off, counted down by the receiver
    bit  src_idle_on   = 1'b1;
    bit  sink_stall_on = 1'b1;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic out_word_t pack_word(logic [1:0] kind, logic [2:0] cls,
                                            logic [7:0] data, logic [2:0] fault,
                                            int levels, logic more, logic done);
        out_word_t r;
        r.out_kind      = kind;
        r.text_class    = cls;
        r.out_byte      = data;
        r.fault_code    = fault;
        r.levels_closed = levels[3:0];
        r.more_follows  = more;
        r.reply_done    = done;
        return r;
    endfunction

    function automatic void clear_length();
        pp_len   = 0;
        pp_neg   = 1'b0;
        pp_digit = 1'b0;
    endfunction

    // one element finished: count down the open arrays, closing the exhausted ones
    function automatic out_word_t close_element(logic [1:0] kind, logic [2:0] cls,
                                                logic [2:0] fault);
        int   levels;
        logic more;
        levels = 0;
        more   = 1'b0;
        while (pp_nest > 0) begin
            if (pp_counts[pp_nest - 1] > 1) begin
                pp_counts[pp_nest - 1] = pp_counts[pp_nest - 1] - 1;
                more = 1'b1;
                break;
            end
            pp_nest = pp_nest - 1;
            levels  = levels + 1;
        end
        pp_phase = P_PREFIX;
        clear_length();
        return pack_word(kind, cls, 8'h00, fault, levels, more, pp_nest == 0);
    endfunction

    // fault that throws away the whole reply
    function automatic out_word_t abort_reply(logic [2:0] cls, logic [2:0] fault);
        pp_nest      = 0;
        pp_phase     = P_PREFIX;
        pp_bulk_left = 0;
        clear_length();
        return pack_word(K_FAULT, cls, 8'h00, fault, 0, 1'b0, 1'b1);
    endfunction

    // advance the predictor by one accepted word, queue any result it gives
    function automatic void parse_word(in_word_t w);
        out_word_t  r;
        logic       has;
        logic [7:0] b;
        has = 1'b0;
        b   = w.rx_byte;
        r   = '0;
        if (w.conn_closed) begin
            pp_class = CL_SIMPLE;
            r        = abort_reply(CL_SIMPLE, F_CLOSED);
            has      = 1'b1;
        end else begin
            case (pp_phase)
                P_PREFIX: begin
                    case (b)
                        CHAR_PLUS: begin
                            pp_class = CL_SIMPLE;
                            pp_phase = P_LINE;
                        end
                        CHAR_MINUS: begin
                            pp_class = CL_ERROR;
                            pp_phase = P_LINE;
                        end
                        CHAR_COLON: begin
                            pp_class = CL_INT;
                            pp_phase = P_LINE;
                        end
                        CHAR_DOLLAR: begin
                            pp_class = CL_BULK;
                            pp_phase = P_LEN;
                            clear_length();
                        end
                        CHAR_STAR: begin
                            pp_class = CL_ARRAY;
                            pp_phase = P_LEN;
                            clear_length();
                        end
                        default: begin
                            // unknown prefix still counts as one element
                            pp_class = CL_SIMPLE;
                            r        = close_element(K_FAULT, CL_SIMPLE, F_UNKNOWN);
                            has      = 1'b1;
                        end
                    endcase
                end
                P_LINE: begin
                    if (b == CHAR_CR) begin
                        pp_phase = P_LINE_LF;
                    end else begin
                        r   = pack_word(K_BYTE, pp_class, b, F_NONE, 0, 1'b0, 1'b0);
                        has = 1'b1;
                    end
                end
                P_LINE_LF: begin
                    r   = close_element(K_END, pp_class, F_NONE);
                    has = 1'b1;
                end
                P_LEN: begin
                    if (b == CHAR_CR) begin
                        pp_phase = P_LEN_LF;
                    end else if (b == CHAR_MINUS && !pp_digit && !pp_neg) begin
                        pp_neg = 1'b1;
                    end else if (b < CHAR_ZERO || b > CHAR_NINE) begin
                        r   = abort_reply(pp_class, F_BADLEN);
                        has = 1'b1;
                    end else begin
                        pp_digit = 1'b1;
                        // saturate one above the limit
                        if (pp_len <= MAX_LENGTH) begin
                            pp_len = pp_len * 10 + int'(b - CHAR_ZERO);
                            if (pp_len > MAX_LENGTH) pp_len = MAX_LENGTH + 1;
                        end
                    end
                end
                P_LEN_LF: begin
                    has = 1'b1;
                    if (!pp_digit) begin
                        r = abort_reply(pp_class, F_BADLEN);
                    end else if (pp_neg && pp_len == 1) begin
                        r = close_element(K_NIL, pp_class, F_NONE);
                    end else if (pp_neg && pp_len != 0) begin
                        r = abort_reply(pp_class, F_BADLEN);
                    end else if (pp_len > MAX_LENGTH) begin
                        r = abort_reply(pp_class, F_TOOLONG);
                    end else if (pp_class == CL_BULK) begin
                        has          = 1'b0;
                        pp_bulk_left = pp_len;
                        pp_phase     = (pp_len != 0) ? P_BULK : P_TRAIL_A;
                        clear_length();
                    end else if (pp_len == 0) begin
                        r = close_element(K_END, CL_ARRAY, F_NONE);
                    end else if (pp_nest >= MAX_DEPTH) begin
                        r = abort_reply(pp_class, F_TOODEEP);
                    end else begin
                        has                = 1'b0;
                        pp_counts[pp_nest] = pp_len;
                        pp_nest            = pp_nest + 1;
                        pp_phase           = P_PREFIX;
                        clear_length();
                    end
                end
                P_BULK: begin
                    if (pp_bulk_left > 0) pp_bulk_left = pp_bulk_left - 1;
                    if (pp_bulk_left == 0) pp_phase = P_TRAIL_A;
                    r   = pack_word(K_BYTE, pp_class, b, F_NONE, 0, 1'b0, 1'b0);
                    has = 1'b1;
                end
                P_TRAIL_A: begin
                    pp_phase = P_TRAIL_B;
                end
                default: begin
                    r   = close_element(K_END, pp_class, F_NONE);
                    has = 1'b1;
                end
            endcase
        end
        if (has) parsed_words.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_field(string name, int e, int a);
        $display("%0t ns: mismatch on %s, expected %0d, actual %0d", $time, name, e, a);
        n_fail++;
    endtask

    task automatic check_result(out_word_t a);
        out_word_t e;
        if (parsed_words.size() == 0) begin
            $display("%0t ns: result word with nothing expected, expected none, actual %h",
                     $time, a);
            n_fail++;
        end else begin
            e = parsed_words.pop_front();
            if (e.out_kind != a.out_kind)
                report_field("out_kind", e.out_kind, a.out_kind);
            if (e.text_class != a.text_class)
                report_field("text_class", e.text_class, a.text_class);
            if (e.out_byte != a.out_byte)
                report_field("out_byte", e.out_byte, a.out_byte);
            if (e.fault_code != a.fault_code)
                report_field("fault_code", e.fault_code, a.fault_code);
            if (e.levels_closed != a.levels_closed)
                report_field("levels_closed", e.levels_closed, a.levels_closed);
            if (e.more_follows != a.more_follows)
                report_field("more_follows", e.more_follows, a.more_follows);
            if (e.reply_done != a.reply_done)
                report_field("reply_done", e.reply_done, a.reply_done);
        end
    endtask

    // sample both channels at the rising edge; predict before checking
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                parse_word(s_data);
                words_in++;
            end
            if (m_valid && m_ready) check_result(m_data);
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("%0t ns: timeout after %0d cycles", $time, cycle_cnt);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random stall bursts, plus a long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                while (hold_cycles > 0) begin
                    @(negedge aclk);
                    hold_cycles--;
                end
            end else if (sink_stall_on && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // sending
    // ------------------------------------------------------------------
    // offer one word at the falling edge and hold it until it is taken
    task automatic send_word(in_word_t w);
        int target;
        if (src_idle_on && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        target = words_in + 1;
        s_valid <= 1'b1;
        s_data  <= w;
        do @(negedge aclk); while (words_in < target);
    endtask

    task automatic put_close();
        in_word_t w;
        w.rx_byte     = 8'($urandom_range(0, 255));
        w.conn_closed = 1'b1;
        send_word(w);
    endtask

    // send the built reply and empty the buffer
    task automatic flush_reply();
        in_word_t w;
        foreach (reply_q[i]) begin
            w.rx_byte     = reply_q[i];
            w.conn_closed = 1'b0;
            send_word(w);
        end
        reply_q.delete();
    endtask

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) reply_q.push_back(s[i]);
    endfunction

    function automatic void add_num(int v);
        add_text($sformatf("%0d", v));
    endfunction

    // cr plus an unchecked byte, usually lf
    function automatic void add_eol();
        reply_q.push_back(CHAR_CR);
        if ($urandom_range(0, 4) == 0) reply_q.push_back(8'($urandom_range(0, 255)));
        else reply_q.push_back(8'h0A);
    endfunction

    function automatic logic [7:0] rand_text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CHAR_CR);
        return b;
    endfunction

    // one well-formed reply with random content and nesting
    task automatic build_reply();
        int   open_left[$];
        int   pick;
        int   n;
        bit   chain;
        bit   opened;
        chain = ($urandom_range(0, 3) == 0);
        reply_q.delete();
        do begin
            opened = 1'b0;
            pick   = $urandom_range(0, 9);
            // deep chains of one- or two-element arrays to reach the nesting limit
            if (chain && open_left.size() <= MAX_DEPTH && $urandom_range(0, 4) != 0) pick = 9;
            if (reply_q.size() > 60) pick = $urandom_range(0, 6);
            case (pick)
                0, 1, 2: begin
                    case ($urandom_range(0, 2))
                        0: reply_q.push_back(CHAR_PLUS);
                        1: reply_q.push_back(CHAR_MINUS);
                        default: reply_q.push_back(CHAR_COLON);
                    endcase
                    repeat ($urandom_range(0, 5)) reply_q.push_back(rand_text_byte());
                    add_eol();
                end
                3, 4: begin
                    n = $urandom_range(0, 6);
                    reply_q.push_back(CHAR_DOLLAR);
                    if (n == 0 && $urandom_range(0, 2) == 0) begin
                        add_text("-0");
                    end else begin
                        if ($urandom_range(0, 3) == 0) add_text("00");
                        add_num(n);
                    end
                    add_eol();
                    repeat (n) reply_q.push_back(8'($urandom_range(0, 255)));
                    add_eol();
                end
                5: begin
                    reply_q.push_back($urandom_range(0, 1) ? CHAR_DOLLAR : CHAR_STAR);
                    add_text("-1");
                    add_eol();
                end
                6: begin
                    logic [7:0] b;
                    do b = 8'($urandom_range(0, 255));
                    while (b inside {CHAR_PLUS, CHAR_MINUS, CHAR_COLON, CHAR_DOLLAR, CHAR_STAR});
                    reply_q.push_back(b);
                end
                default: begin
                    n = chain ? $urandom_range(1, 2) : $urandom_range(0, 3);
                    reply_q.push_back(CHAR_STAR);
                    add_num(n);
                    add_eol();
                    if (n > 0) begin
                        open_left.push_back(n);
                        opened = 1'b1;
                    end
                end
            endcase
            if (!opened) begin
                while (open_left.size() > 0) begin
                    if (open_left[open_left.size() - 1] > 1) begin
                        open_left[open_left.size() - 1] = open_left[open_left.size() - 1] - 1;
                        break;
                    end
                    void'(open_left.pop_back());
                end
            end
        end while (open_left.size() > 0);
    endtask

    // a reply whose length line is broken, or huge and cut off by a close
    task automatic build_broken(output bit needs_close);
        logic [7:0] b;
        needs_close = 1'b0;
        reply_q.delete();
        reply_q.push_back($urandom_range(0, 1) ? CHAR_DOLLAR : CHAR_STAR);
        case ($urandom_range(0, 7))
            0: ;
            1: begin
                add_text("-");
                add_num($urandom_range(2, 99999));
            end
            2: begin
                add_num($urandom_range(0, 99));
                do b = 8'($urandom_range(0, 255));
                while (b inside {CHAR_CR, [CHAR_ZERO:CHAR_NINE]});
                reply_q.push_back(b);
            end
            3: add_text("--");
            4: add_num(MAX_LENGTH + 1 + $urandom_range(0, 1000));
            5: add_num($urandom_range(100000, 99999999));
            6: begin
                add_num(MAX_LENGTH);
                add_eol();
                repeat ($urandom_range(3, 8)) reply_q.push_back(rand_text_byte());
                needs_close = 1'b1;
            end
            default: add_text("1-");
        endcase
        if (!needs_close) add_eol();
    endtask

    // mostly well-formed replies, some cut short, some broken, some junk
    task automatic send_random_traffic(int n_words);
        int start;
        int sel;
        bit needs_close;
        start = words_in;
        while (words_in - start < n_words) begin
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                build_reply();
                if ($urandom_range(0, 7) == 0) begin
                    while (reply_q.size() > $urandom_range(1, reply_q.size()))
                        void'(reply_q.pop_back());
                    flush_reply();
                    put_close();
                end else begin
                    flush_reply();
                end
            end else if (sel < 9) begin
                build_broken(needs_close);
                flush_reply();
                if (needs_close) put_close();
            end else begin
                repeat ($urandom_range(1, 4)) reply_q.push_back(8'($urandom_range(0, 255)));
                flush_reply();
                if ($urandom_range(0, 1) == 0) put_close();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // simple, error and integer lines, extreme content bytes, odd byte after cr
    task automatic test_line_replies();
        reply_q.push_back(CHAR_PLUS);
        reply_q.push_back(8'h00);
        reply_q.push_back(8'hFF);
        reply_q.push_back(CHAR_CR);
        reply_q.push_back(8'h5A);
        add_text("-ERR x\r\n:-12\r\n+\r\n");
        flush_reply();
    endtask

    // bulk bodies with cr inside, empty, nil, minus zero, leading zeros
    task automatic test_bulk_strings();
        add_text("$2\r\n");
        reply_q.push_back(CHAR_CR);
        reply_q.push_back(8'h80);
        add_text("\r\n$0\r\n\r\n$-1\r\n$-0\r\nzz$007\r\nabcdefg\r\n");
        flush_reply();
    endtask

    // empty length, other negatives, bad characters, over-long and saturated lengths
    task automatic test_length_faults();
        add_text("$\r\n*-2\r\n$1-*--$x$65536\r\n*9999999\r\n");
        flush_reply();
    endtask

    // empty and nil arrays, unknown prefix as element, multi-level close, depth limit
    task automatic test_arrays();
        add_text("*3\r\n:1\r\n*0\r\n*-1\r\n*2\r\n?*1\r\n+\r\n");
        repeat (MAX_DEPTH) add_text("*1\r\n");
        add_text(":0\r\n");
        repeat (MAX_DEPTH + 1) add_text("*1\r\n");
        flush_reply();
    endtask

    // close while idle, mid-line, inside a maximum bulk and a maximum array
    task automatic test_conn_close();
        put_close();
        add_text("+ab");
        flush_reply();
        put_close();
        add_text("*2\r\n$65535\r\nxy");
        flush_reply();
        put_close();
        add_text("*65535\r\n:1\r\n");
        flush_reply();
        put_close();
    endtask

    task automatic test_random_replies();
        send_random_traffic(340);
    endtask

    // receiver holds off long enough for the parser to fill and stall its input
    task automatic test_receiver_holdoff();
        hold_cycles = 200;
        send_random_traffic(60);
    endtask

    // no idling on either side
    task automatic test_back_to_back();
        src_idle_on   = 1'b0;
        sink_stall_on = 1'b0;
        send_random_traffic(60);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_line_replies();
        test_bulk_strings();
        test_length_faults();
        test_arrays();
        test_conn_close();
        test_random_replies();
        test_receiver_holdoff();
        test_back_to_back();

        // drain: wait for every predicted word, then check that no stray word follows
        s_valid <= 1'b0;
        while (parsed_words.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (n_fail == 0 && parsed_words.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/rrsp_pkg.sv
rtl/core/rrsp_front.sv
rtl/core/rrsp_queue.sv
rtl/core/rrsp_back.sv
rtl/core/resp_reply_stream_parser.sv
tb/sv/tb.sv
